// ===== hw/rtl/hlp_pkg.sv =====
package hlp_pkg;

  // most hex digits allowed after the 0x prefix (1..16)
  localparam int unsigned MaxDigits = 16;
  localparam int unsigned CountW    = 5;

  localparam logic [7:0] ChNewline = 8'd10;
  localparam logic [7:0] ChSpace   = 8'd32;
  localparam logic [7:0] ChTab     = 8'd9;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChLowX    = 8'h78;
  localparam logic [7:0] ChUpX     = 8'h58;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_X,
    PH_FIRST,
    PH_DIGITS,
    PH_TRAIL,
    PH_DISCARD
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_PREFIX,
    ST_LONG,
    ST_TRAIL
  } status_e;

  // decoded character class
  typedef struct packed {
    logic       is_hex;
    logic [3:0] digit;
    logic       is_blank;
    logic       is_nl;
  } char_t;

  function automatic char_t decode_char(logic [7:0] c);
    char_t r;
    r.is_hex   = 1'b0;
    r.digit    = 4'd0;
    r.is_blank = (c == ChSpace) || (c == ChTab);
    r.is_nl    = (c == ChNewline);
    if (c >= 8'h30 && c <= 8'h39) begin
      r.is_hex = 1'b1;
      r.digit  = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.is_hex = 1'b1;
      r.digit  = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/hex_literal_line_parser_core.sv =====
// Hex literal line parser. One ASCII character per beat on ch_i; lines end
// with a newline (10). Leading spaces and tabs are skipped, then the line must
// hold "0x" or "0X" and a nonzero hex digit, then up to MaxDigits hex digits,
// then only blanks up to the newline. At the newline a status_o of 0 beat
// carries the value; any violation gives an error beat at once (1 bad prefix
// or empty line, 2 too many digits, 3 bad trailing character, value zero) and
// the rest of the line up to its newline is dropped. One character is taken
// every cycle while in_stall_o is low: each is parsed in the cycle it is
// accepted, straight into the line state and the result register. A
// one-entry skid register behind the result register keeps input flowing
// while a result waits; in_stall_o is high only while that skid entry holds
// a result, so while results are taken it sustains one character per cycle.
module hex_literal_line_parser_core import hlp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [63:0] value_o
);

  // line state
  phase_e              phase_q, phase_d;
  logic [63:0]         acc_q, acc_d;
  logic [CountW-1:0]   cnt_q, cnt_d;

  // result register and skid entry
  logic                out_valid_q, skid_valid_q;
  status_e             out_status_q, skid_status_q;
  logic [63:0]         out_value_q, skid_value_q;

  logic                in_acc;
  logic                res_vld;
  status_e             res_status;
  logic [63:0]         res_value;
  logic                out_take;
  char_t               chr;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;
  assign chr        = decode_char(ch_i);

  // one parsing step per accepted character
  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    res_vld    = 1'b0;
    res_status = ST_OK;
    res_value  = '0;
    unique case (phase_q)
      PH_LEAD: begin
        if (chr.is_blank) begin
          phase_d = PH_LEAD;
        end else if (ch_i == ChZero) begin
          phase_d = PH_X;
        end else begin
          res_vld    = 1'b1;
          res_status = ST_PREFIX;
        end
      end
      PH_X: begin
        if (ch_i == ChLowX || ch_i == ChUpX) begin
          phase_d = PH_FIRST;
        end else begin
          res_vld    = 1'b1;
          res_status = ST_PREFIX;
        end
      end
      PH_FIRST: begin
        if (chr.is_hex && chr.digit != 4'd0) begin
          acc_d   = {60'd0, chr.digit};
          cnt_d   = CountW'(1);
          phase_d = PH_DIGITS;
        end else begin
          res_vld    = 1'b1;
          res_status = ST_PREFIX;
        end
      end
      PH_DIGITS: begin
        if (chr.is_hex) begin
          if (cnt_q >= CountW'(MaxDigits)) begin
            res_vld    = 1'b1;
            res_status = ST_LONG;
          end else begin
            acc_d = {acc_q[59:0], chr.digit};
            cnt_d = cnt_q + CountW'(1);
          end
        end else if (chr.is_nl) begin
          res_vld   = 1'b1;
          res_value = acc_q;
        end else if (chr.is_blank) begin
          phase_d = PH_TRAIL;
        end else begin
          res_vld    = 1'b1;
          res_status = ST_TRAIL;
        end
      end
      PH_TRAIL: begin
        if (chr.is_nl) begin
          res_vld   = 1'b1;
          res_value = acc_q;
        end else if (!chr.is_blank) begin
          res_vld    = 1'b1;
          res_status = ST_TRAIL;
        end
      end
      default: begin
        // dropping the rest of a failed line
        if (chr.is_nl) begin
          phase_d = PH_LEAD;
        end
      end
    endcase
    // any result closes the line; an error not on a newline drops the rest
    if (res_vld) begin
      acc_d   = '0;
      cnt_d   = '0;
      phase_d = (res_status != ST_OK && !chr.is_nl) ? PH_DISCARD : PH_LEAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc && res_vld) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_status_q <= skid_status_q;
        out_value_q  <= skid_value_q;
      end
    end else if (in_acc && res_vld) begin
      if (!out_valid_q || out_take) begin
        out_status_q <= res_status;
        out_value_q  <= res_value;
      end else begin
        skid_status_q <= res_status;
        skid_value_q  <= res_value;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign value_o     = out_value_q;

  // skid entry only fills behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output register is empty");

  // error results carry zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_OK) |-> (out_value_q == '0))
    else $error("error result with nonzero value");

  // digit count stays within the limit and is nonzero while digits run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DIGITS || phase_q == PH_TRAIL) |->
      (cnt_q != '0 && cnt_q <= CountW'(MaxDigits)))
    else $error("digit count out of range");

  // an accepted newline always starts a fresh line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ch_i == ChNewline) |=> (phase_q == PH_LEAD && cnt_q == '0))
    else $error("newline did not restart the line");

  // a result-producing beat is never lost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_vld) |=> (out_valid_q || skid_valid_q))
    else $error("result dropped");

endmodule
